FILE: hw/rtl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and constants for the button gesture detector: sample and result
// beats, per-button state entry, gesture codes and register indexes.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int NUM_BUTTONS_DEF = 3;
  localparam int MAX_BUTTONS     = 3;
  localparam int TW              = 48;
  localparam int MSW             = 16;
  localparam int USW             = 26;
  localparam int US_PER_MS       = 1000;

  localparam logic [2:0] REG_HOLD_TIMES   = 3'd0;
  localparam logic [2:0] REG_REPEAT_TIMES = 3'd1;
  localparam logic [2:0] REG_EXTRA_TIMES  = 3'd2;
  localparam logic [2:0] REG_DEB_WINDOW   = 3'd3;
  localparam logic [2:0] REG_FITTED_MASK  = 3'd4;

  localparam logic [TW-1:0]  HOLD_TIMES_RST   = 48'd2147581952500;
  localparam logic [TW-1:0]  REPEAT_TIMES_RST = 48'd773094113460;
  localparam logic [TW-1:0]  EXTRA_TIMES_RST  = 48'd327680000;
  localparam logic [MSW-1:0] DEB_WINDOW_RST   = 16'd30;
  localparam logic [2:0]     FITTED_MASK_RST  = 3'd7;

  typedef enum logic [2:0] {
    GEST_NONE   = 3'd0,
    GEST_TAP    = 3'd1,
    GEST_HOLD   = 3'd2,
    GEST_REPEAT = 3'd3,
    GEST_EXTRA  = 3'd4
  } gesture_t;

  typedef struct packed {
    logic [1:0]    button_index;
    logic          pressed;
    logic [TW-1:0] now_time;
  } sample_t;

  typedef struct packed {
    logic [1:0] button_id;
    gesture_t   gesture;
    logic       busy_res;
    logic       last;
  } result_t;

  typedef struct packed {
    logic          is_down;
    logic [TW-1:0] press_time;
    logic [TW-1:0] release_time;
    logic [TW-1:0] repeat_due;
    logic          hold_reported;
    logic          extra_reported;
  } entry_t;

endpackage

FILE: hw/rtl/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector
// Path: an accepted sample is held in the stage 1 registers, then its result in the output register.
// Throughput: one sample per cycle while the output does not stall; a sample
// that yields two results holds the pipe until the output register's second beat is taken.
// Per-button state sits in a one-port-read, one-port-write memory; forwarding
// covers a write and a read of the same button at one edge.
// Reset: valid bits clear so all state reads as zero; registers take defaults.
// ----------------------------------------------------------------------------
module button_gesture_detector #(
  parameter int NUM_BUTTONS = bgd_pkg::NUM_BUTTONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  bgd_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output bgd_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [47:0]      cfg_data
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int IW = (AW > 2) ? AW : 2;

  logic [47:0] hold_times;
  logic [47:0] repeat_times;
  logic [47:0] extra_times;
  logic [15:0] deb_window;
  logic [2:0]  fitted_mask;

  function automatic logic [15:0] lane(input logic [47:0] r, input logic [1:0] i);
    logic [15:0] v;
    unique case (i)
      2'd0:    v = r[15:0];
      2'd1:    v = r[31:16];
      2'd2:    v = r[47:32];
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [bgd_pkg::USW-1:0] to_us(input logic [15:0] ms);
    return bgd_pkg::USW'(ms) * bgd_pkg::USW'(bgd_pkg::US_PER_MS);
  endfunction

  function automatic logic ge_us(input logic [47:0] now, input logic [47:0] t,
                                 input logic [bgd_pkg::USW-1:0] thr);
    logic [48:0] d;
    d = {1'b0, now} - {1'b0, t};
    return !d[48] && (d[47:0] >= 48'(thr));
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_times   <= bgd_pkg::HOLD_TIMES_RST;
      repeat_times <= bgd_pkg::REPEAT_TIMES_RST;
      extra_times  <= bgd_pkg::EXTRA_TIMES_RST;
      deb_window   <= bgd_pkg::DEB_WINDOW_RST;
      fitted_mask  <= bgd_pkg::FITTED_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bgd_pkg::REG_HOLD_TIMES:   hold_times   <= cfg_data;
        bgd_pkg::REG_REPEAT_TIMES: repeat_times <= cfg_data;
        bgd_pkg::REG_EXTRA_TIMES:  extra_times  <= cfg_data;
        bgd_pkg::REG_DEB_WINDOW:   deb_window   <= cfg_data[15:0];
        bgd_pkg::REG_FITTED_MASK:  fitted_mask  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // stage 0: accept, select lanes, issue read
  logic          accept;
  logic [3:0]    fit4;
  logic          ok0;
  logic [IW-1:0] idx_w;
  logic [AW-1:0] addr0;

  assign accept = sample_valid && !sample_stall;
  assign fit4   = {1'b0, fitted_mask};
  assign ok0    = (sample.button_index != 2'd3) &&
                  (int'(sample.button_index) < NUM_BUTTONS) &&
                  fit4[sample.button_index];
  assign idx_w  = IW'(sample.button_index);
  assign addr0  = ok0 ? idx_w[AW-1:0] : '0;

  // stage 1 registers
  logic                      s1_valid;
  bgd_pkg::sample_t          s1_sample;
  logic                      s1_ok;
  logic [AW-1:0]             s1_addr;
  logic [bgd_pkg::USW-1:0]   s1_hold_us;
  logic [bgd_pkg::USW-1:0]   s1_rep_us;
  logic [bgd_pkg::USW-1:0]   s1_extra_us;
  logic [bgd_pkg::USW-1:0]   s1_deb_us;
  logic                      s1_fwd;
  logic                      rd_vld;
  bgd_pkg::entry_t           rd_entry;
  bgd_pkg::entry_t           fwd_entry;
  bgd_pkg::entry_t           cur;
  bgd_pkg::entry_t           entry_next;
  logic                      s1_adv;
  logic                      wr_en;

  bgd_pkg::entry_t mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vld;

  assign wr_en = s1_adv && s1_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= sample;
      s1_ok       <= ok0;
      s1_addr     <= addr0;
      s1_hold_us  <= to_us(lane(hold_times, sample.button_index));
      s1_rep_us   <= to_us(lane(repeat_times, sample.button_index));
      s1_extra_us <= to_us(lane(extra_times, sample.button_index));
      s1_deb_us   <= to_us(deb_window);
      s1_fwd      <= wr_en && (s1_addr == addr0);
      rd_vld      <= vld[addr0];
      rd_entry    <= mem[addr0];
    end
    if (wr_en) begin
      fwd_entry <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[s1_addr] <= 1'b1;
    end
  end

  // stage 1: read-modify-write
  bgd_pkg::gesture_t ga;
  bgd_pkg::gesture_t gb;
  logic              busy;
  logic              two;
  logic [48:0]       due_sum;
  logic [47:0]       due;
  logic [47:0]       now;

  assign now     = s1_sample.now_time;
  assign due_sum = {1'b0, now} + 49'(s1_rep_us);
  assign due     = due_sum[48] ? {48{1'b1}} : due_sum[47:0];

  always_comb begin
    cur        = s1_fwd ? fwd_entry : (rd_vld ? rd_entry : '0);
    entry_next = cur;
    ga         = bgd_pkg::GEST_NONE;
    gb         = bgd_pkg::GEST_NONE;
    busy       = 1'b0;
    if (s1_ok) begin
      priority if (s1_sample.pressed && !cur.is_down) begin
        busy = 1'b1;
        if (ge_us(now, cur.release_time, s1_deb_us)) begin
          entry_next.is_down        = 1'b1;
          entry_next.press_time     = now;
          entry_next.hold_reported  = 1'b0;
          entry_next.extra_reported = 1'b0;
          entry_next.repeat_due     = '0;
        end
      end else if (s1_sample.pressed) begin
        busy = 1'b1;
        if (s1_hold_us != '0 && !cur.hold_reported &&
            ge_us(now, cur.press_time, s1_hold_us)) begin
          entry_next.hold_reported = 1'b1;
          entry_next.repeat_due    = due;
          ga = bgd_pkg::GEST_HOLD;
        end else if (cur.hold_reported && s1_rep_us != '0 &&
                     now >= cur.repeat_due) begin
          entry_next.repeat_due = due;
          ga = bgd_pkg::GEST_REPEAT;
        end
        if (s1_extra_us != '0 && !cur.extra_reported &&
            ge_us(now, cur.press_time, s1_extra_us)) begin
          entry_next.extra_reported = 1'b1;
          gb = bgd_pkg::GEST_EXTRA;
        end
      end else if (cur.is_down) begin
        entry_next.is_down      = 1'b0;
        entry_next.release_time = now;
        if (!cur.hold_reported && ge_us(now, cur.press_time, s1_deb_us)) begin
          ga = bgd_pkg::GEST_TAP;
        end
      end else begin
      end
    end
    two = (ga != bgd_pkg::GEST_NONE) && (gb != bgd_pkg::GEST_NONE);
  end

  // output register with one pending second beat
  logic              pend;
  bgd_pkg::gesture_t pend_gest;

  assign s1_adv       = s1_valid && (!result_valid || (!result_stall && !pend));
  assign sample_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend         <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
      pend         <= two;
    end else if (result_valid && !result_stall) begin
      if (pend) begin
        pend <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.button_id <= s1_sample.button_index;
      result.gesture   <= (ga != bgd_pkg::GEST_NONE) ? ga : gb;
      result.busy_res  <= busy;
      result.last      <= !two;
      pend_gest        <= gb;
    end else if (result_valid && !result_stall && pend) begin
      result.gesture <= pend_gest;
      result.last    <= 1'b1;
    end
  end

endmodule
